// File: rtl/rrfd_pkg.sv
package rrfd_pkg;

   // history geometry
   localparam int HIST_DEPTH = 20;
   localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

   // field widths
   localparam int ADDR_W  = 64;
   localparam int LEN_W   = 7;
   localparam int SEQ_W   = 8;
   localparam int SHORT_W = 16;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [SHORT_W-1:0] SHORT_BCAST   = 16'hffff;
   localparam logic [LEN_W-1:0]   ACK_FRAME_LEN = 7'd3;

   // command codes
   localparam logic CMD_RX = 1'b0;
   localparam logic CMD_TX = 1'b1;

   // ack modes
   localparam logic [MODE_W-1:0] ACK_MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] ACK_MODE_HW   = 2'd1;
   localparam logic [MODE_W-1:0] ACK_MODE_SW   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_MODE = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_ACK       = 3'd0,
      VERDICT_TOO_SHORT = 3'd1,
      VERDICT_PARSE     = 3'd2,
      VERDICT_NOT_OURS  = 3'd3,
      VERDICT_DUP       = 3'd4,
      VERDICT_DELIVER   = 3'd5,
      VERDICT_TX        = 3'd6
   } verdict_type;

   typedef struct packed {
      logic               command;
      logic [LEN_W-1:0]   frame_len;
      logic               ack_request;
      logic [SEQ_W-1:0]   seq_number;
      logic               parse_ok;
      logic               dest_short;
      logic [ADDR_W-1:0]  dest_address;
      logic               src_short;
      logic [ADDR_W-1:0]  src_address;
   } item_type;

   typedef struct packed {
      verdict_type        verdict;
      logic               send_ack;
      logic [SEQ_W-1:0]   ack_seq;
      logic               broadcast_hit;
      logic               last_ack_valid;
      logic [SEQ_W-1:0]   last_ack_seq;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  sender;
      logic [SEQ_W-1:0]   seq;
      logic [LEN_W-1:0]   len;
   } hist_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_step;
      logic commit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic slot_free;
   } dp_status_type;

endpackage

// File: rtl/rrfd_if.sv
interface rrfd_req_if;
   import rrfd_pkg::*;
   logic                valid;
   logic                ready;
   logic                command;
   logic [LEN_W-1:0]    frame_len;
   logic                ack_request;
   logic [SEQ_W-1:0]    seq_number;
   logic                parse_ok;
   logic                dest_short;
   logic [ADDR_W-1:0]   dest_address;
   logic                src_short;
   logic [ADDR_W-1:0]   src_address;

   modport source (output valid, command, frame_len, ack_request, seq_number, parse_ok,
                   dest_short, dest_address, src_short, src_address, input ready);
   modport sink   (input valid, command, frame_len, ack_request, seq_number, parse_ok,
                   dest_short, dest_address, src_short, src_address, output ready);
endinterface

interface rrfd_rsp_if;
   import rrfd_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          verdict;
   logic                send_ack;
   logic [SEQ_W-1:0]    ack_seq;
   logic                broadcast_hit;
   logic                last_ack_valid;
   logic [SEQ_W-1:0]    last_ack_seq;

   modport source (output valid, verdict, send_ack, ack_seq, broadcast_hit,
                   last_ack_valid, last_ack_seq, input ready);
   modport sink   (input valid, verdict, send_ack, ack_seq, broadcast_hit,
                   last_ack_valid, last_ack_seq, output ready);
endinterface

interface rrfd_csr_if;
   import rrfd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [ADDR_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rrfd_ctrl.sv
module rrfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rrfd_pkg::dp_status_type status,
   output rrfd_pkg::ctrl_cmd_type  cmd
);
   import rrfd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.scan_clear = (state_ff == ST_EVAL);
      cmd.scan_step  = (state_ff == ST_SCAN);
      cmd.commit     = (state_ff == ST_FINISH) && status.slot_free;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EVAL;
                  ready_ff <= 1'b0;
               end
            end
            ST_EVAL: begin
               state_ff <= status.need_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
               if (status.scan_last) state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (status.slot_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == ST_IDLE)
      else $error("ready raised outside idle");
`endif

endmodule

// File: rtl/rrfd_datapath.sv
module rrfd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rrfd_pkg::item_type              req_item,
   input  logic                            csr_we,
   input  logic [rrfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rrfd_pkg::ADDR_W-1:0]     csr_data,
   input  rrfd_pkg::ctrl_cmd_type          cmd,
   output rrfd_pkg::dp_status_type         status,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output rrfd_pkg::rsp_type               rsp_word
);
   import rrfd_pkg::*;

   item_type                item_ff;
   logic [ADDR_W-1:0]       own_addr_ff;
   logic [MODE_W-1:0]       ack_mode_ff;
   hist_entry_type          hist_ff [HIST_DEPTH];
   logic [HIST_IDX_W-1:0]   ptr_ff;
   logic [HIST_IDX_W-1:0]   idx_ff;
   logic                    dup_ff;
   logic                    ack_valid_ff;
   logic [SEQ_W-1:0]        ack_seq_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic                    is_tx, too_short, is_ack, is_frame;
   logic [SHORT_W-1:0]      dest_lo, src_lo;
   logic                    bcast, ours, need_scan;
   verdict_type             early_verdict, final_verdict;
   hist_entry_type          entry;
   logic                    sender_hit, hit;
   logic                    ack_valid_in;
   logic [SEQ_W-1:0]        ack_seq_in;
   logic                    send_ack;
   logic                    slot_free;

   // frame classification
   assign is_tx     = (item_ff.command == CMD_TX);
   assign too_short = (item_ff.frame_len < ACK_FRAME_LEN);
   assign is_ack    = (item_ff.frame_len == ACK_FRAME_LEN);
   assign is_frame  = !is_tx && !too_short && !is_ack;
   assign dest_lo   = item_ff.dest_address[SHORT_W-1:0];
   assign src_lo    = item_ff.src_address[SHORT_W-1:0];
   assign bcast     = item_ff.dest_short && (dest_lo == SHORT_BCAST);
   assign ours      = item_ff.dest_short ? (bcast || dest_lo == own_addr_ff[SHORT_W-1:0])
                                         : (item_ff.dest_address == own_addr_ff);
   assign need_scan = is_frame && item_ff.parse_ok && ours;
   assign send_ack  = is_frame && (ack_mode_ff == ACK_MODE_SW) && item_ff.ack_request;

   always_comb begin
      if (is_tx)                 early_verdict = VERDICT_TX;
      else if (too_short)        early_verdict = VERDICT_TOO_SHORT;
      else if (is_ack)           early_verdict = VERDICT_ACK;
      else if (!item_ff.parse_ok) early_verdict = VERDICT_PARSE;
      else if (!ours)            early_verdict = VERDICT_NOT_OURS;
      else                       early_verdict = VERDICT_DELIVER;
   end

   assign final_verdict = (need_scan && dup_ff) ? VERDICT_DUP : early_verdict;

   // history compare, one entry per cycle
   assign entry      = hist_ff[idx_ff];
   assign sender_hit = item_ff.src_short
                       ? (src_lo != SHORT_BCAST && entry.sender[SHORT_W-1:0] == src_lo)
                       : (entry.sender == item_ff.src_address);
   assign hit        = sender_hit && (entry.seq == item_ff.seq_number)
                       && (entry.len == item_ff.frame_len);

   // last-ack state after this word
   always_comb begin
      ack_valid_in = ack_valid_ff;
      ack_seq_in   = ack_seq_ff;
      if (is_tx) begin
         ack_valid_in = 1'b0;
      end else if (is_ack) begin
         ack_valid_in = 1'b1;
         ack_seq_in   = item_ff.seq_number;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status           = '0;
      status.need_scan = need_scan;
      status.scan_last = (idx_ff == HIST_IDX_W'(HIST_DEPTH - 1));
      status.slot_free = slot_free;
   end

   // input capture and scan state
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_item;
      if (cmd.scan_clear) begin
         idx_ff <= '0;
         dup_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= status.scan_last ? '0 : idx_ff + 1'b1;
         dup_ff <= dup_ff || hit;
      end
   end

   // config, history, last-ack state, output register
   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff  <= '0;
         ack_mode_ff  <= ACK_MODE_NONE;
         ptr_ff       <= '0;
         ack_valid_ff <= 1'b0;
         ack_seq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) hist_ff[i] <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_ADDR: own_addr_ff <= csr_data;
               CSR_ACK_MODE: ack_mode_ff <= csr_data[MODE_W-1:0];
               default: ;
            endcase
         end
         // a new word, or the held word until it is taken
         rsp_valid_ff <= cmd.commit || (rsp_valid_ff && !rsp_ready);
         if (cmd.commit) begin
            ack_valid_ff <= ack_valid_in;
            ack_seq_ff   <= ack_seq_in;
            if (need_scan && !dup_ff) begin
               hist_ff[ptr_ff].sender[SHORT_W-1:0] <= src_lo;
               if (!item_ff.src_short)
                  hist_ff[ptr_ff].sender[ADDR_W-1:SHORT_W] <=
                     item_ff.src_address[ADDR_W-1:SHORT_W];
               hist_ff[ptr_ff].seq <= item_ff.seq_number;
               hist_ff[ptr_ff].len <= item_ff.frame_len;
               ptr_ff <= (ptr_ff == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
            end
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.verdict        <= final_verdict;
         rsp_ff.send_ack       <= send_ack;
         rsp_ff.ack_seq        <= send_ack ? item_ff.seq_number : '0;
         rsp_ff.broadcast_hit  <= is_frame && item_ff.parse_ok && bcast;
         rsp_ff.last_ack_valid <= ack_valid_in;
         rsp_ff.last_ack_seq   <= ack_seq_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> slot_free)
      else $error("result committed over an untaken word");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise result valid");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= HIST_IDX_W'(HIST_DEPTH - 1))
      else $error("insert pointer out of range");
`endif

endmodule

// File: rtl/radio_rx_frame_filter_dedup.sv
// An accepted word is captured and classified; a word addressed to us then walks
// all HIST_DEPTH history entries, one entry per cycle, before its result is committed.
// A result is committed only when the output slot is free, and a new word is accepted
// only after the previous result has been committed.
// Reset (synchronous, active high) clears history, pointer, last-ack state and config.
module radio_rx_frame_filter_dedup (
   input  logic        clock,
   input  logic        reset,
   rrfd_req_if.sink    req_ch,
   rrfd_rsp_if.source  rsp_ch,
   rrfd_csr_if.sink    csr_ch
);
   import rrfd_pkg::*;

   item_type       req_item;
   rsp_type        rsp_word;
   ctrl_cmd_type   cmd;
   dp_status_type  status;
   logic           csr_we;

   // gather the input word
   always_comb begin
      req_item.command      = req_ch.command;
      req_item.frame_len    = req_ch.frame_len;
      req_item.ack_request  = req_ch.ack_request;
      req_item.seq_number   = req_ch.seq_number;
      req_item.parse_ok     = req_ch.parse_ok;
      req_item.dest_short   = req_ch.dest_short;
      req_item.dest_address = req_ch.dest_address;
      req_item.src_short    = req_ch.src_short;
      req_item.src_address  = req_ch.src_address;
   end

   // config writes always taken
   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid;

   rrfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrfd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_word  (rsp_word)
   );

   // result word out
   assign rsp_ch.verdict        = rsp_word.verdict;
   assign rsp_ch.send_ack       = rsp_word.send_ack;
   assign rsp_ch.ack_seq        = rsp_word.ack_seq;
   assign rsp_ch.broadcast_hit  = rsp_word.broadcast_hit;
   assign rsp_ch.last_ack_valid = rsp_word.last_ack_valid;
   assign rsp_ch.last_ack_seq   = rsp_word.last_ack_seq;

endmodule
